[design/nv12rgb_pkg.sv]
`default_nettype none

package nv12rgb_pkg;

    // Fixed-point format of the color gains
    localparam int COEF_FRAC_BITS = 14;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = GAIN_W;

    // Centered samples: 8-bit value minus 8-bit offset, signed
    localparam int CEN_W  = PIX_W + 1;
    // Unsigned gain times signed centered chroma
    localparam int PROD_W = GAIN_W + CEN_W;
    // Channel sum: y * 2^F plus or minus up to two products, with headroom
    localparam int BASE_W = CEN_W + COEF_FRAC_BITS;
    localparam int SUM_W  = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 2;

    localparam int LANES    = 4;
    localparam int IN_W     = (LANES + 2) * PIX_W;
    localparam int OUT_W    = LANES * 3 * PIX_W;

    // Register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_CR_TO_RED     = 3'd0,
        REG_CB_TO_GREEN   = 3'd1,
        REG_CR_TO_GREEN   = 3'd2,
        REG_CB_TO_BLUE    = 3'd3,
        REG_LUMA_OFFSET   = 3'd4,
        REG_CHROMA_OFFSET = 3'd5
    } reg_index_t;

    // Reset values (Q2.14 gains)
    localparam logic [GAIN_W-1:0] RST_CR_TO_RED     = 16'd22458;
    localparam logic [GAIN_W-1:0] RST_CB_TO_GREEN   = 16'd5532;
    localparam logic [GAIN_W-1:0] RST_CR_TO_GREEN   = 16'd11436;
    localparam logic [GAIN_W-1:0] RST_CB_TO_BLUE    = 16'd28385;
    localparam logic [PIX_W-1:0]  RST_LUMA_OFFSET   = 8'd16;
    localparam logic [PIX_W-1:0]  RST_CHROMA_OFFSET = 8'd128;

    typedef struct packed {
        logic [GAIN_W-1:0] cr_to_red;
        logic [GAIN_W-1:0] cb_to_green;
        logic [GAIN_W-1:0] cr_to_green;
        logic [GAIN_W-1:0] cb_to_blue;
        logic [PIX_W-1:0]  luma_offset;
        logic [PIX_W-1:0]  chroma_offset;
    } cfg_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctl_t;

    // Chroma terms shared by all four lanes
    typedef struct packed {
        logic signed [PROD_W-1:0] red_cr;
        logic signed [PROD_W-1:0] green_cb;
        logic signed [PROD_W-1:0] green_cr;
        logic signed [PROD_W-1:0] blue_cb;
    } chroma_prod_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

endpackage

`default_nettype wire

[design/nv12rgb_chroma.sv]
`default_nettype none

module nv12rgb_chroma
    import nv12rgb_pkg::*;
(
    input  wire logic             clk,
    input  wire pipe_ctl_t        ctl,
    input  wire cfg_t             cfg,
    input  wire logic [PIX_W-1:0] chroma_blue,
    input  wire logic [PIX_W-1:0] chroma_red,
    output chroma_prod_t          prod
);

    logic signed [CEN_W-1:0] cb_next;
    logic signed [CEN_W-1:0] cr_next;
    logic signed [CEN_W-1:0] cb_reg;
    logic signed [CEN_W-1:0] cr_reg;
    chroma_prod_t            prod_next;
    chroma_prod_t            prod_reg;

    // Stage 1: remove the chroma zero level
    always_comb
    begin
        cb_next = $signed({1'b0, chroma_blue}) - $signed({1'b0, cfg.chroma_offset});
        cr_next = $signed({1'b0, chroma_red})  - $signed({1'b0, cfg.chroma_offset});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            cb_reg <= cb_next;
            cr_reg <= cr_next;
        end
    end

    // Stage 2: the four gain products, registered
    always_comb
    begin
        prod_next.red_cr   = PROD_W'($signed({1'b0, cfg.cr_to_red}))   * PROD_W'(cr_reg);
        prod_next.green_cb = PROD_W'($signed({1'b0, cfg.cb_to_green})) * PROD_W'(cb_reg);
        prod_next.green_cr = PROD_W'($signed({1'b0, cfg.cr_to_green})) * PROD_W'(cr_reg);
        prod_next.blue_cb  = PROD_W'($signed({1'b0, cfg.cb_to_blue}))  * PROD_W'(cb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[design/nv12rgb_lane.sv]
`default_nettype none

module nv12rgb_lane
    import nv12rgb_pkg::*;
(
    input  wire logic             clk,
    input  wire pipe_ctl_t        ctl,
    input  wire logic [PIX_W-1:0] luma,
    input  wire logic [PIX_W-1:0] luma_offset,
    input  wire chroma_prod_t     prod,
    output rgb_t                  pix
);

    logic signed [CEN_W-1:0] y_next;
    logic signed [CEN_W-1:0] y1_reg;
    logic signed [CEN_W-1:0] y2_reg;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] red_sum;
    logic signed [SUM_W-1:0] green_sum;
    logic signed [SUM_W-1:0] blue_sum;
    rgb_t                    pix_next;
    rgb_t                    pix_reg;

    // Clamp to 0..255, dropping the fraction bits
    function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] r;
        if (s[SUM_W-1] || (s == '0))
        begin
            r = '0;
        end
        else if (|s[SUM_W-2:COEF_FRAC_BITS+PIX_W])
        begin
            r = '1;
        end
        else
        begin
            r = s[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
        end
        return r;
    endfunction

    // Stage 1: remove the black level
    assign y_next = $signed({1'b0, luma}) - $signed({1'b0, luma_offset});

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            y1_reg <= y_next;
        end
        if (ctl.en2)
        begin
            y2_reg <= y1_reg;
        end
    end

    // Stage 3: channel sums and clamp
    always_comb
    begin
        base      = SUM_W'(y2_reg) <<< COEF_FRAC_BITS;
        red_sum   = base + SUM_W'(prod.red_cr);
        green_sum = base - SUM_W'(prod.green_cb) - SUM_W'(prod.green_cr);
        blue_sum  = base + SUM_W'(prod.blue_cb);
        pix_next.red   = clamp_channel(red_sum);
        pix_next.green = clamp_channel(green_sum);
        pix_next.blue  = clamp_channel(blue_sum);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

`default_nettype wire

[design/nv12_quad_to_rgb_top.sv]
`default_nettype none

// Channel  Dir  Width  Contents
// s_axis   in   48     one 2x2 luma quad with its shared Cb/Cr pair
// m_axis   out  96     four RGB pixels of the quad
// cfg      in   16     gain and offset register writes, no read-back
//
// Three-stage pipeline, one quad per clock while m_axis does not stall; an
// accepted beat passes through centering, the shared gain multipliers and
// the per-lane sum and clamp, in that order, each one registered stage,
// and the output stage drives m_axis.
// Reset loads the default gains and offsets and empties the pipeline.
// A stall on m_axis fills free stages first; s_axis_tready drops only when
// all three stages hold a beat.

module nv12_quad_to_rgb_top
    import nv12rgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red
    input  wire logic [IN_W-1:0]    s_axis_tdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // red/green/blue of top_left, top_right, bottom_left, bottom_right
    output logic [OUT_W-1:0]        m_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic               cfg_wen,
    input  wire logic [CIDX_W-1:0]  cfg_index,
    input  wire logic [CDATA_W-1:0] cfg_wdata
);

    cfg_t         cfg_reg;
    logic         v1_reg;
    logic         v2_reg;
    logic         v3_reg;
    logic         room1;
    logic         room2;
    logic         room3;
    pipe_ctl_t    ctl;
    chroma_prod_t prod;
    rgb_t         pix [LANES];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cr_to_red     <= RST_CR_TO_RED;
            cfg_reg.cb_to_green   <= RST_CB_TO_GREEN;
            cfg_reg.cr_to_green   <= RST_CR_TO_GREEN;
            cfg_reg.cb_to_blue    <= RST_CB_TO_BLUE;
            cfg_reg.luma_offset   <= RST_LUMA_OFFSET;
            cfg_reg.chroma_offset <= RST_CHROMA_OFFSET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_CR_TO_RED:     cfg_reg.cr_to_red     <= cfg_wdata;
                REG_CB_TO_GREEN:   cfg_reg.cb_to_green   <= cfg_wdata;
                REG_CR_TO_GREEN:   cfg_reg.cr_to_green   <= cfg_wdata;
                REG_CB_TO_BLUE:    cfg_reg.cb_to_blue    <= cfg_wdata;
                REG_LUMA_OFFSET:   cfg_reg.luma_offset   <= cfg_wdata[PIX_W-1:0];
                REG_CHROMA_OFFSET: cfg_reg.chroma_offset <= cfg_wdata[PIX_W-1:0];
                default:           ;
            endcase
        end
    end

    // Pipeline flow: a stage loads when it is empty or its successor moves
    always_comb
    begin
        room3 = !v3_reg || m_axis_tready;
        room2 = !v2_reg || room3;
        room1 = !v1_reg || room2;
        ctl.en1 = room1 && s_axis_tvalid;
        ctl.en2 = room2 && v1_reg;
        ctl.en3 = room3 && v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (room1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (room2)
            begin
                v2_reg <= v1_reg;
            end
            if (room3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign s_axis_tready = room1;
    assign m_axis_tvalid = v3_reg;

    // Shared chroma terms
    nv12rgb_chroma u_chroma (
        .clk         (clk),
        .ctl         (ctl),
        .cfg         (cfg_reg),
        .chroma_blue (s_axis_tdata[4*PIX_W +: PIX_W]),
        .chroma_red  (s_axis_tdata[5*PIX_W +: PIX_W]),
        .prod        (prod)
    );

    // One lane per luma sample; lane outputs merge into the result beat
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        nv12rgb_lane u_lane (
            .clk         (clk),
            .ctl         (ctl),
            .luma        (s_axis_tdata[k*PIX_W +: PIX_W]),
            .luma_offset (cfg_reg.luma_offset),
            .prod        (prod),
            .pix         (pix[k])
        );

        assign m_axis_tdata[k*3*PIX_W +: 3*PIX_W] = pix[k];
    end

    // Accepted beat lands in the first stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted beat missing from first stage");

    // Input back-pressure only with every stage occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && !m_axis_tready))
        else $error("input stalled with a free stage");

    // A free output stage never blocks input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // Second stage moves into the output stage when it has room
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && room3) |=> m_axis_tvalid)
        else $error("beat lost between stage two and output");

endmodule

`default_nettype wire
